[rtl/dpp_pkg.sv]
// shared types, constants and helpers of the depth pixel to posed point block
`default_nettype none

package dpp_pkg;

  // largest image size the datapath handles
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  // pose words: nine rotation words row-major, then three translation words
  localparam int unsigned NumPose  = 12;
  localparam int unsigned TransBase = 9;
  localparam logic signed [31:0] OneQ28 = 32'sh1000_0000;

  // configuration register indexes
  localparam logic [2:0] CfgImageWidth  = 3'd0;
  localparam logic [2:0] CfgImageHeight = 3'd1;
  localparam logic [2:0] CfgInvFocal    = 3'd2;
  localparam logic [2:0] CfgNearMm      = 3'd3;
  localparam logic [2:0] CfgFarMm       = 3'd4;

  // item opcodes
  localparam logic OpPixel    = 1'b0;
  localparam logic OpPoseLoad = 1'b1;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [23:0] inv_focal_q24;
    logic [15:0] near_mm;
    logic [15:0] far_mm;
  } cfg_t;

  // fields of a point that only ride along the pipeline
  typedef struct packed {
    logic [17:0] point_index;
    logic        point_valid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        frame_last;
  } side_t;

  // pose word load carried in order with the pixels
  typedef struct packed {
    logic               is_load;
    logic [3:0]         idx;
    logic signed [31:0] value;
  } load_t;

  // item leaving the back-projection stages
  typedef struct packed {
    load_t              ld;
    side_t              side;
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } bp_item_t;

  // clamp a 40-bit signed value to signed 32 bits
  function automatic logic [31:0] sat32(input logic [39:0] v);
    logic [31:0] r;
    if (!v[39] && (|v[38:31])) begin
      r = 32'h7fff_ffff;
    end else if (v[39] && !(&v[38:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/dpp_backproj.sv]
// pixel filter and pinhole back-projection stages, four registers deep
`default_nettype none

module dpp_backproj import dpp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              opcode_i,
  input  wire logic [9:0]        row_i,
  input  wire logic [9:0]        column_i,
  input  wire logic [15:0]       depth_mm_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  input  wire logic [3:0]        coef_index_i,
  input  wire logic signed [31:0] coef_value_i,
  output logic                   bp_valid_o,
  input  wire logic              bp_stall_i,
  output bp_item_t               bp_item_o
);

  localparam logic [10:0] WMax = 11'(MaxWidth);
  localparam logic [10:0] HMax = 11'(MaxHeight);

  // stage enables, bubbles collapse toward the output
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en4 = !v4_q || !bp_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 1: clamp geometry, filter pixel, offsets and slot index
  logic [10:0] w, h;
  logic        emit, accept, v1_d;
  logic [11:0] dx, dy;
  logic [18:0] slot_prod;
  logic [10:0] last_r, last_c;
  side_t       side1_d;
  load_t       ld1_d;

  always_comb begin
    w = (cfg_i.image_width > WMax) ? WMax : cfg_i.image_width;
    h = (cfg_i.image_height > HMax) ? HMax : cfg_i.image_height;
    emit = !row_i[0] && !column_i[0] && ({1'b0, row_i} < h) && ({1'b0, column_i} < w);
    accept = in_valid_i && en1;
    v1_d = accept && ((opcode_i == OpPoseLoad) || emit);
    dx = {1'b0, column_i, 1'b0} - {1'b0, w};
    dy = {1'b0, row_i, 1'b0} - {1'b0, h};
    slot_prod = row_i[9:1] * w[10:1];
    last_r = (h - 11'd1) & ~11'd1;
    last_c = (w - 11'd1) & ~11'd1;
    side1_d.point_index = slot_prod[17:0] + {9'd0, column_i[9:1]};
    side1_d.point_valid = (depth_mm_i > cfg_i.near_mm) && (depth_mm_i < cfg_i.far_mm);
    side1_d.red = red_i;
    side1_d.green = green_i;
    side1_d.blue = blue_i;
    side1_d.frame_last = ({1'b0, row_i} == last_r) && ({1'b0, column_i} == last_c);
    ld1_d.is_load = (opcode_i == OpPoseLoad);
    ld1_d.idx = coef_index_i;
    ld1_d.value = coef_value_i;
  end

  logic [10:0] ax1_q, ay1_q;
  logic        nx1_q, ny1_q;
  logic [15:0] dep1_q;
  side_t       side1_q;
  load_t       ld1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ax1_q <= dx[11] ? 11'(-dx) : dx[10:0];
      ay1_q <= dy[11] ? 11'(-dy) : dy[10:0];
      nx1_q <= dx[11];
      ny1_q <= dy[11];
      dep1_q <= depth_mm_i;
      side1_q <= side1_d;
      ld1_q <= ld1_d;
    end
  end

  // stage 2: offset magnitude times depth
  logic [26:0] mx2_q, my2_q;
  logic        nx2_q, ny2_q;
  logic [15:0] dep2_q;
  side_t       side2_q;
  load_t       ld2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mx2_q <= ax1_q * dep1_q;
      my2_q <= ay1_q * dep1_q;
      nx2_q <= nx1_q;
      ny2_q <= ny1_q;
      dep2_q <= dep1_q;
      side2_q <= side1_q;
      ld2_q <= ld1_q;
    end
  end

  // stage 3: scale by the reciprocal focal length
  logic [50:0] mx3_q, my3_q;
  logic        nx3_q, ny3_q;
  logic [15:0] dep3_q;
  side_t       side3_q;
  load_t       ld3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      mx3_q <= mx2_q * cfg_i.inv_focal_q24;
      my3_q <= my2_q * cfg_i.inv_focal_q24;
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      dep3_q <= dep2_q;
      side3_q <= side2_q;
      ld3_q <= ld2_q;
    end
  end

  // stage 4: round half away from zero, restore sign, saturate
  logic [51:0] rx_sum, ry_sum;
  logic [35:0] rx, ry, sx, sy;
  bp_item_t    item4_d, item4_q;

  always_comb begin
    rx_sum = {1'b0, mx3_q} + 52'h1_0000;
    ry_sum = {1'b0, my3_q} + 52'h1_0000;
    rx = {1'b0, rx_sum[51:17]};
    ry = {1'b0, ry_sum[51:17]};
    sx = nx3_q ? -rx : rx;
    sy = ny3_q ? -ry : ry;
    item4_d.ld = ld3_q;
    item4_d.side = side3_q;
    item4_d.p0 = sat32({{4{sx[35]}}, sx});
    item4_d.p1 = sat32({{4{sy[35]}}, sy});
    item4_d.p2 = {8'd0, dep3_q, 8'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      item4_q <= item4_d;
    end
  end

  assign bp_valid_o = v4_q;
  assign bp_item_o = item4_q;

endmodule

`default_nettype wire

[rtl/depth_pixel_to_posed_point.sv]
// top level: configuration, pose words and rigid transform stages
//
// Depth pixels go through a seven-register pipeline: four stages filter the
// pixel and back-project it, three stages apply the rotation and translation
// and the fixed axis swap. One item is accepted every clock unless every stage
// is full and the output is stalled; a result moves through the stage
// registers in order and leaves from the output register of stage 7.
// Odd pixels, pixels outside the image and pose loads give no result and
// leave a bubble that later items close up. A pose load takes effect for every
// pixel accepted after it, even while earlier pixels are still in flight.
// Users must write configuration registers only while the pipeline is empty (not enforced).
`default_nettype none

module depth_pixel_to_posed_point import dpp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               opcode_i,
  input  wire logic [9:0]         row_i,
  input  wire logic [9:0]         column_i,
  input  wire logic [15:0]        depth_mm_i,
  input  wire logic [7:0]         red_i,
  input  wire logic [7:0]         green_i,
  input  wire logic [7:0]         blue_i,
  input  wire logic [3:0]         coef_index_i,
  input  wire logic signed [31:0] coef_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [17:0]             point_index_o,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o,
  output logic                    point_valid_o,
  output logic [7:0]              out_red_o,
  output logic [7:0]              out_green_o,
  output logic [7:0]              out_blue_o,
  output logic                    frame_last_o
);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width <= 11'd640;
      cfg_q.image_height <= 11'd480;
      cfg_q.inv_focal_q24 <= 24'd31957;
      cfg_q.near_mm <= 16'd500;
      cfg_q.far_mm <= 16'd3000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgImageWidth: cfg_q.image_width <= cfg_data_i[10:0];
        CfgImageHeight: cfg_q.image_height <= cfg_data_i[10:0];
        CfgInvFocal: cfg_q.inv_focal_q24 <= cfg_data_i;
        CfgNearMm: cfg_q.near_mm <= cfg_data_i[15:0];
        CfgFarMm: cfg_q.far_mm <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // back-projection stages
  logic     bp_valid, bp_stall;
  bp_item_t bp_item;

  dpp_backproj u_backproj (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .row_i,
    .column_i,
    .depth_mm_i,
    .red_i,
    .green_i,
    .blue_i,
    .coef_index_i,
    .coef_value_i,
    .bp_valid_o   (bp_valid),
    .bp_stall_i   (bp_stall),
    .bp_item_o    (bp_item)
  );

  // stage enables of the rigid transform
  logic en5, en6, en7;
  logic v5_q, v6_q, v7_q;

  assign en7 = !v7_q || !out_stall_i;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign bp_stall = !en5;

  // pose words, written when a load passes the stage that reads them
  logic signed [31:0] pose_q [NumPose];
  logic               pose_we;

  assign pose_we = bp_valid && en5 && bp_item.ld.is_load && (bp_item.ld.idx < 4'(NumPose));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumPose; k++) begin
        pose_q[k] <= ((k == 0) || (k == 4) || (k == 8)) ? OneQ28 : 32'sd0;
      end
    end else if (pose_we) begin
      pose_q[bp_item.ld.idx] <= bp_item.ld.value;
    end
  end

  // stage 5: nine rotation products, translation taken alongside
  logic signed [63:0] prod5_q [3][3];
  logic signed [31:0] t5_q [3];
  side_t              side5_q;
  logic signed [31:0] pv [3];

  assign pv[0] = bp_item.p0;
  assign pv[1] = bp_item.p1;
  assign pv[2] = bp_item.p2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en5) begin
      v5_q <= bp_valid && !bp_item.ld.is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod5_q[i][j] <= pose_q[i * 3 + j] * pv[j];
        end
        t5_q[i] <= pose_q[TransBase + i];
      end
      side5_q <= bp_item.side;
    end
  end

  // stage 6: exact row sums, round half up, drop the Q28 fraction
  logic signed [65:0] sum6 [3];
  logic signed [37:0] r6_q [3];
  logic signed [31:0] t6_q [3];
  side_t              side6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum6[i] = {{2{prod5_q[i][0][63]}}, prod5_q[i][0]}
              + {{2{prod5_q[i][1][63]}}, prod5_q[i][1]}
              + {{2{prod5_q[i][2][63]}}, prod5_q[i][2]}
              + 66'sh800_0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en6) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      for (int i = 0; i < 3; i++) begin
        r6_q[i] <= sum6[i][65:28];
        t6_q[i] <= t5_q[i];
      end
      side6_q <= side5_q;
    end
  end

  // stage 7: translate, swap axes, saturate (zero for an invalid point) into the output register
  logic signed [38:0] q7 [3];
  logic [39:0]        ex, ey, ez;
  logic [31:0]        pos_x_q, pos_y_q, pos_z_q;
  side_t              side7_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q7[i] = {r6_q[i][37], r6_q[i]} + {{7{t6_q[i][31]}}, t6_q[i]};
    end
    ex = {q7[2][38], q7[2]};
    ey = -{q7[0][38], q7[0]};
    ez = -{q7[1][38], q7[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en7) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en7) begin
      pos_x_q <= side6_q.point_valid ? sat32(ex) : 32'd0;
      pos_y_q <= side6_q.point_valid ? sat32(ey) : 32'd0;
      pos_z_q <= side6_q.point_valid ? sat32(ez) : 32'd0;
      side7_q <= side6_q;
    end
  end

  assign out_valid_o = v7_q;
  assign point_index_o = side7_q.point_index;
  assign pos_x_o = pos_x_q;
  assign pos_y_o = pos_y_q;
  assign pos_z_o = pos_z_q;
  assign point_valid_o = side7_q.point_valid;
  assign out_red_o = side7_q.red;
  assign out_green_o = side7_q.green;
  assign out_blue_o = side7_q.blue;
  assign frame_last_o = side7_q.frame_last;

  // an out-of-range point carries zero coordinates
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> pos_x_o == 0 && pos_y_o == 0 && pos_z_o == 0)
    else $error("invalid point with nonzero coordinates");

  // the input is held back only when every stage is full and the output blocked
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // a pose word changes only when a load item leaves the back-projection stages
  a_pose_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_we |-> bp_valid && !bp_stall && bp_item.ld.is_load)
    else $error("pose word written out of order");

endmodule

`default_nettype wire
